// File: hw/rtl/positional_insert_delete_array_top_macros.svh
// Assertion macros for the positional insert/delete array.
// Both forms sample on clk; the first is masked while rst is high.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_TOP_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PIDA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PIDA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIDA_ASSERT(name, prop, msg)
`define PIDA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: hw/rtl/pida_pkg.sv
`default_nettype none

package pida_pkg;

  localparam int WORD_W       = 32;
  localparam int OP_W         = 3;
  localparam int ST_W         = 2;
  localparam int DEF_CAPACITY = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_ROT
  } pida_cmd_t;

  // word: new value on insert, front element on rotate
  typedef struct packed {
    pida_cmd_t         cmd;
    logic [WORD_W-1:0] word;
  } pida_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/pida_cell.sv
`default_nettype none

// One slot of the list. Takes its own word, a neighbor's word or the
// broadcast word, depending on the command and where it sits.
module pida_cell
  import pida_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  wire logic              clk,
  input  wire pida_ctl_t         ctl,
  input  wire logic [CNT_W-1:0]  pos,
  input  wire logic [CNT_W-1:0]  cnt,
  input  wire logic [WORD_W-1:0] lower_word,
  input  wire logic [WORD_W-1:0] upper_word,
  output logic      [WORD_W-1:0] word
);

  localparam logic [CNT_W-1:0] IDX_V   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_NXT = CNT_W'(IDX + 1);

  logic [WORD_W-1:0] word_next;

  // Slot update select
  always_comb begin
    word_next = word;
    unique case (ctl.cmd)
      CMD_HOLD: word_next = word;
      CMD_INS: begin
        if (IDX_V == pos) begin
          word_next = ctl.word;
        end else if (IDX_V > pos && IDX_V <= cnt) begin
          word_next = lower_word;
        end
      end
      CMD_DEL: begin
        if (IDX_V >= pos && IDX_NXT < cnt) begin
          word_next = upper_word;
        end
      end
      CMD_ROT: begin
        if (IDX_NXT < cnt) begin
          word_next = upper_word;
        end else if (IDX_NXT == cnt) begin
          word_next = ctl.word;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/positional_insert_delete_array_top.sv
// Channel | Direction | Handshake          | Fields
// input   | in        | in_valid/in_stall  | operation, position, value
// output  | out       | out_valid/out_stall| status, data, count, last
//
// Clear, append, insert, delete and unknown codes give one transaction each; the
// cell row shifts every slot at once, so these run one a cycle while output is free.
// Dump enters a dump state, then sends one transaction per element held: the row rotates
// toward slot 0 and slot 0 is sent, so it paces at the output channel; input stalls.
// Reset clears the count and the control; slot contents stay undefined.
// Output stall holds the output register; a new item is taken once it frees.
`default_nettype none

`include "positional_insert_delete_array_top_macros.svh"

module positional_insert_delete_array_top
  import pida_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          operation,
  input  wire logic [CNT_W-1:0]         position,
  input  wire logic signed [WORD_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ST_W-1:0]               status,
  output logic signed [WORD_W-1:0]      data,
  output logic [CNT_W-1:0]              count,
  output logic                          last
);

  localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_V = CNT_W'(1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  dump_left;
  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [WORD_W-1:0] del_word;
  pida_ctl_t         ctl;
  logic [CNT_W-1:0]  cell_pos;
  logic [ST_W-1:0]   res_status;
  logic [WORD_W-1:0] res_data;
  logic              acc;
  logic              slot_free;
  logic              out_load;

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] lower_w;
    logic [WORD_W-1:0] upper_w;
    if (g == 0) begin : g_lo_end
      assign lower_w = '0;
    end else begin : g_lo
      assign lower_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi_end
      assign upper_w = '0;
    end else begin : g_hi
      assign upper_w = cell_word[g+1];
    end
    pida_cell #(
      .CNT_W(CNT_W),
      .IDX  (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (cell_pos),
      .cnt       (cnt),
      .lower_word(lower_w),
      .upper_word(upper_w),
      .word      (cell_word[g])
    );
  end

  // Handshake
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !slot_free;
  assign acc       = in_valid && !in_stall;

  // Output register load
  assign out_load = (state == S_DUMP) ? slot_free
                                      : (acc && !(operation == OP_DUMP && cnt != '0));

  // Word at the delete position
  always_comb begin
    del_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (position == CNT_W'(i)) begin
        del_word = cell_word[i];
      end
    end
  end

  // Operation decode and cell command
  always_comb begin
    ctl.cmd    = CMD_HOLD;
    ctl.word   = $unsigned(value);
    cell_pos   = position;
    cnt_next   = cnt;
    res_status = ST_OK;
    res_data   = '0;
    if (state == S_DUMP) begin
      if (slot_free) begin
        ctl.cmd  = CMD_ROT;
        ctl.word = cell_word[0];
        cell_pos = '0;
      end
    end else if (acc) begin
      case (operation)
        OP_CLEAR: cnt_next = '0;
        OP_APPEND: begin
          if (cnt == CAP_V) begin
            res_status = ST_FULL;
          end else begin
            ctl.cmd  = CMD_INS;
            cell_pos = cnt;
            cnt_next = cnt + ONE_V;
          end
        end
        OP_INSERT: begin
          if (cnt == CAP_V) begin
            res_status = ST_FULL;
          end else if (position > cnt) begin
            res_status = ST_RANGE;
          end else begin
            ctl.cmd  = CMD_INS;
            cnt_next = cnt + ONE_V;
          end
        end
        OP_DELETE: begin
          if (cnt == '0) begin
            res_status = ST_EMPTY;
          end else if (position >= cnt) begin
            res_status = ST_RANGE;
          end else begin
            ctl.cmd  = CMD_DEL;
            res_data = del_word;
            cnt_next = cnt - ONE_V;
          end
        end
        OP_DUMP: begin
          if (cnt == '0) begin
            res_status = ST_EMPTY;
          end
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  // State, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (operation == OP_DUMP && cnt != '0) begin
              state     <= S_DUMP;
              dump_left <= cnt;
            end else begin
              status    <= res_status;
              data      <= $signed(res_data);
              count     <= cnt_next;
              last      <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            status    <= ST_OK;
            data      <= $signed(cell_word[0]);
            count     <= cnt;
            last      <= (dump_left == ONE_V);
            dump_left <= dump_left - ONE_V;
            if (dump_left == ONE_V) begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  // Checks
  `PIDA_ASSERT(a_cnt_bound, (cnt <= CAP_V), "element count above capacity")
  `PIDA_ASSERT(a_dump_nonempty, ((state == S_DUMP) |-> (cnt != '0 && dump_left != '0)),
               "dump running on an empty list")
  `PIDA_ASSERT(a_single_result, ((acc && operation != OP_DUMP) |=> (out_valid && last)),
               "single-result item gave no final transaction")
  `PIDA_ASSERT(a_cnt_step, ((state == S_DUMP) |=> (cnt == $past(cnt))),
               "count changed during dump")

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pida_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int POS_W        = $clog2(CAPACITY + 1);
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 400000;

  // Operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct {
    logic [ST_W-1:0]          status;
    logic signed [WORD_W-1:0] data;
    logic [POS_W-1:0]         count;
    logic                     last;
  } list_result_t;

  // Mirror of the list plus the queue of results still owed by the block
  class array_scoreboard;
    logic signed [WORD_W-1:0] slots [CAPACITY];
    int unsigned              held;
    list_result_t             owed_q [$];
    int                       errors;
    int                       n_inputs;
    int                       n_results;
    int                       n_dumps;
    int                       peak_held;
    int                       status_seen [4];

    function void owe(logic [ST_W-1:0] st, logic signed [WORD_W-1:0] d, logic lst);
      list_result_t r;
      r.status = st;
      r.data   = d;
      r.count  = POS_W'(held);
      r.last   = lst;
      owed_q.push_back(r);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted transaction to the mirror and queue what it owes
    function void note_input(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [WORD_W-1:0] val);
      logic signed [WORD_W-1:0] gone;
      n_inputs++;
      case (op)
        OP_CLEAR: begin
          held = 0;
          owe(ST_OK, '0, 1'b1);
        end
        OP_APPEND: begin
          if (held >= CAPACITY) begin
            owe(ST_FULL, '0, 1'b1);
          end else begin
            slots[held] = val;
            held++;
            owe(ST_OK, '0, 1'b1);
          end
        end
        OP_INSERT: begin
          // full check wins over a bad position
          if (held >= CAPACITY) begin
            owe(ST_FULL, '0, 1'b1);
          end else if (pos > held) begin
            owe(ST_RANGE, '0, 1'b1);
          end else begin
            for (int i = held; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = val;
            held++;
            owe(ST_OK, '0, 1'b1);
          end
        end
        OP_DELETE: begin
          if (held == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else if (pos >= held) begin
            owe(ST_RANGE, '0, 1'b1);
          end else begin
            gone = slots[pos];
            for (int i = pos; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
            owe(ST_OK, gone, 1'b1);
          end
        end
        OP_DUMP: begin
          n_dumps++;
          if (held == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < held; i++) owe(ST_OK, slots[i], (i + 1 == held));
          end
        end
        default: owe(ST_OK, '0, 1'b1);
      endcase
      if (held > peak_held) peak_held = held;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one accepted output transaction against the oldest owed result
    task check_result(logic [ST_W-1:0] st, logic signed [WORD_W-1:0] d,
                      logic [POS_W-1:0] c, logic lst);
      list_result_t want;
      n_results++;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result status %0d data %0d count %0d last %0d",
                         st, d, c, lst));
        return;
      end
      want = owed_q.pop_front();
      status_seen[want.status]++;
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (d !== want.data)
        report($sformatf("data %0d, want %0d", d, want.data));
      if (c !== want.count)
        report($sformatf("count %0d, want %0d", c, want.count));
      if (lst !== want.last)
        report($sformatf("last %0d, want %0d", lst, want.last));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          operation = OP_CLEAR;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ST_W-1:0]          status;
  logic signed [WORD_W-1:0] data;
  logic [POS_W-1:0]         count;
  logic                     last;

  array_scoreboard sb = new();

  int       cycle_cnt = 0;
  int       burst_left = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       n_holds = 0;
  int       n_drains = 0;
  bit       hold_request = 1'b0;
  rx_mode_t rx_mode = RX_FREE;

  positional_insert_delete_array_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data      (data),
    .count     (count),
    .last      (last)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Output side: check accepted transactions, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(status, data, count, last);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
        n_holds++;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_stall <= cycle_cnt[0];
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  function automatic logic signed [WORD_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Offer one transaction, wait until taken, then idle if the burst ended
  task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [WORD_W-1:0] val);
    int gap;
    gap = 0;
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, pos, val);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender goes quiet until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    n_drains++;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic noise_item();
    send_item(OP_W'($urandom_range(0, 7)), rand_pos(), rand_value());
  endtask

  // Build the list up to capacity, push past it, then list it
  task automatic grow_list();
    while (sb.held < CAPACITY) begin
      if ($urandom_range(0, 9) == 0)
        noise_item();
      else if ($urandom_range(0, 1) == 0)
        send_item(OP_APPEND, rand_pos(), rand_value());
      else
        send_item(OP_INSERT, POS_W'($urandom_range(0, sb.held)), rand_value());
    end
    repeat ($urandom_range(1, 3))
      send_item($urandom_range(0, 1) ? OP_APPEND : OP_INSERT, rand_pos(), rand_value());
    send_item(OP_DUMP, rand_pos(), rand_value());
  endtask

  // Take the list apart from random positions
  task automatic shrink_list();
    while (sb.held > 0) begin
      case ($urandom_range(0, 19))
        0, 1:    send_item(OP_DELETE, POS_W'($urandom_range(sb.held, (1 << POS_W) - 1)),
                           rand_value());
        2:       send_item(OP_DUMP, rand_pos(), rand_value());
        default: send_item(OP_DELETE, POS_W'($urandom_range(0, sb.held - 1)),
                           rand_value());
      endcase
    end
    send_item(OP_DELETE, rand_pos(), rand_value());
    send_item(OP_DUMP, rand_pos(), rand_value());
  endtask

  initial begin
    int  target;
    bit  first_hold;
    bit  second_hold;
    first_hold  = 1'b0;
    second_hold = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extremes of value and position, spare codes
    send_item(OP_DUMP,   5'd0,  32'sd0);
    send_item(OP_DELETE, 5'd31, 32'sd0);
    send_item(OP_INSERT, 5'd1,  32'sd7);
    send_item(OP_INSERT, 5'd0,  32'sh8000_0000);
    send_item(OP_APPEND, 5'd31, 32'sh7fff_ffff);
    send_item(OP_APPEND, 5'd0,  -32'sd1);
    send_item(OP_INSERT, 5'd3,  32'sd0);
    send_item(OP_INSERT, 5'd1,  32'sh5555_5555);
    send_item(OP_INSERT, 5'd6,  32'shaaaa_aaaa);
    send_item(OP_DELETE, 5'd5,  32'sd0);
    send_item(OP_DELETE, 5'd0,  32'sd0);
    send_item(OP_DELETE, 5'd3,  32'sd0);
    send_item(OP_DUMP,   5'd16, 32'sd0);
    send_item(OP_SPARE_A, 5'd2,  32'sh1234_5678);
    send_item(OP_SPARE_B, 5'd31, -32'sd1);
    send_item(OP_SPARE_C, 5'd0,  32'sh8000_0000);
    send_item(OP_DUMP,   5'd0,  32'sd0);
    send_item(OP_CLEAR,  5'd9,  32'sd0);
    send_item(OP_DUMP,   5'd0,  32'sd0);
    drain();

    // Random: mostly grow/shrink episodes with random content
    target = sb.n_inputs + RANDOM_ITEMS;
    while (sb.n_inputs < target) begin
      if (!first_hold && sb.n_inputs > target - 350) begin
        hold_request = 1'b1;
        first_hold = 1'b1;
      end
      if (!second_hold && sb.n_inputs > target - 120) begin
        hold_request = 1'b1;
        second_hold = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: grow_list();
        4, 5, 6:    shrink_list();
        7:          repeat (20) noise_item();
        8: begin
          send_item(OP_CLEAR, rand_pos(), rand_value());
          send_item(OP_DUMP, rand_pos(), rand_value());
        end
        default:    drain();
      endcase
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("run: %0d transactions in, %0d out, %0d dumps, longest list %0d",
             sb.n_inputs, sb.n_results, sb.n_dumps, sb.peak_held);
    $display("status ok %0d, full %0d, empty %0d, range %0d; %0d holds, %0d drains",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], n_holds, n_drains);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
